[hw/rtl/mmrc_pkg.sv]
// Shared constants, types and the CRC step for the meter reply checker.
`default_nettype none

package mmrc_pkg;

    // Frame layout and counter width.
    localparam int unsigned CNT_W           = 6;
    localparam int unsigned MAX_FRAME_DEF   = 40;
    localparam int unsigned MIN_FRAME       = 29;
    localparam int unsigned NUM_READINGS    = 6;
    localparam int unsigned READING_W       = 32;
    localparam int unsigned FIRST_READ_BYTE = 3;
    localparam int unsigned BYTES_PER_READ  = 4;

    // CRC-16 as used on Modbus RTU links.
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] ADDR_RESET = 8'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ADDR  = 2'd1,
        ST_CRC_ERR   = 2'd2,
        ST_TOO_SHORT = 2'd3
    } status_t;

    typedef logic [READING_W-1:0] reading_t;

    // Advance a reflected CRC-16 by one byte, one bit per loop pass.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/mmrc_if.sv]
// Valid/ready channel interfaces for incoming frame bytes and outgoing reply results.
`default_nettype none

interface mmrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mmrc_reply_if;
    logic               valid;
    logic               ready;
    mmrc_pkg::reading_t voltage;
    mmrc_pkg::reading_t current;
    mmrc_pkg::reading_t power;
    mmrc_pkg::reading_t energy;
    mmrc_pkg::reading_t power_factor;
    mmrc_pkg::reading_t carbon;
    logic [1:0]         status;

    modport source (output valid, output voltage, output current, output power,
                    output energy, output power_factor, output carbon, output status,
                    input ready);
    modport sink   (input valid, input voltage, input current, input power,
                    input energy, input power_factor, input carbon, input status,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/modbus_meter_reply_checker.sv]
// Top level: checks a Modbus RTU meter reply frame and emits readings plus status.
`default_nettype none

//  Channel  | Dir | Payload                                          | Handshake
//  rx       | in  | rx_byte[7:0], frame_end                          | valid/ready
//  reply    | out | voltage..carbon (6 x 32 bit), status[1:0]        | valid/ready
//  cfg      | in  | cfg_wdata[7:0] -> device address                 | cfg_we, no wait
//
// One byte request is taken every cycle unless a frame end is held by a stalled reply; a byte
// reaches the frame state when it leaves the byte stage register, and the result of a frame is
// loaded into the result register when its last byte leaves the byte stage.
// The CRC step is one byte-wide XOR network between the byte register and the CRC register.
// Reset clears the frame state and sets the device address to 1; no clearing pass is needed.
// A stalled reply holds the final byte of the next frame in the byte stage, which blocks the bytes behind it.

module modbus_meter_reply_checker #(
    parameter int unsigned MAX_FRAME = mmrc_pkg::MAX_FRAME_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mmrc_byte_if.sink       rx,
    mmrc_reply_if.source    reply,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);
    import mmrc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] SHORT_LIM = CNT_W'(MIN_FRAME - 1);

    // Configuration.
    logic [7:0] dev_addr_reg;

    // Byte stage.
    logic       st_valid_reg;
    logic [7:0] st_byte_reg;
    logic       st_end_reg;

    // Frame state.
    logic [CNT_W-1:0] cnt_reg,       cnt_next;
    logic [15:0]      crc_now_reg,   crc_now_next;
    logic [15:0]      crc_dly_reg,   crc_dly_next;
    logic [7:0]       last_byte_reg, last_byte_next;
    logic             addr_ok_reg,   addr_ok_next;
    reading_t         rd_reg  [NUM_READINGS];
    reading_t         rd_next [NUM_READINGS];

    // Result register.
    logic     out_valid_reg, out_valid_next;
    reading_t out_rd_reg [NUM_READINGS];
    status_t  out_status_reg;

    logic    advance;
    logic    out_load;
    logic    addr_ok_now;
    status_t status_now;

    // Handshake: the byte stage moves on unless a frame end meets a full result slot that is not being taken.
    assign advance  = st_valid_reg && (!st_end_reg || !out_valid_reg || reply.ready);
    assign out_load = advance && st_end_reg;
    assign rx.ready = !st_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_addr_reg <= ADDR_RESET;
        else if (cfg_we)
            dev_addr_reg <= cfg_wdata;
    end

    // Byte stage register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else if (rx.ready)
            st_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            st_byte_reg <= rx.rx_byte;
            st_end_reg  <= rx.frame_end;
        end
    end

    // Frame status from the current byte and the stored frame state.
    always_comb
    begin
        addr_ok_now = (cnt_reg == '0) ? (st_byte_reg == dev_addr_reg) : addr_ok_reg;
        if (cnt_reg < SHORT_LIM)
            status_now = ST_TOO_SHORT;
        else if (!addr_ok_now)
            status_now = ST_BAD_ADDR;
        else if (last_byte_reg != crc_dly_reg[7:0] || st_byte_reg != crc_dly_reg[15:8])
            status_now = ST_CRC_ERR;
        else
            status_now = ST_OK;
    end

    // Next frame state: clear at the frame end, otherwise absorb the byte.
    always_comb
    begin
        cnt_next       = cnt_reg;
        crc_now_next   = crc_now_reg;
        crc_dly_next   = crc_dly_reg;
        last_byte_next = last_byte_reg;
        addr_ok_next   = addr_ok_reg;
        for (int j = 0; j < NUM_READINGS; j++)
            rd_next[j] = rd_reg[j];

        if (advance)
        begin
            if (st_end_reg)
            begin
                cnt_next       = '0;
                crc_now_next   = CRC_INIT;
                crc_dly_next   = CRC_INIT;
                last_byte_next = '0;
                addr_ok_next   = 1'b0;
                for (int j = 0; j < NUM_READINGS; j++)
                    rd_next[j] = '0;
            end
            else
            begin
                addr_ok_next   = addr_ok_now;
                crc_dly_next   = crc_now_reg;
                crc_now_next   = crc_byte(crc_now_reg, st_byte_reg);
                last_byte_next = st_byte_reg;
                if (cnt_reg < MAX_CNT)
                    cnt_next = cnt_reg + CNT_W'(1);
                for (int j = 0; j < NUM_READINGS; j++)
                begin
                    if (32'(cnt_reg) >= FIRST_READ_BYTE + BYTES_PER_READ * j &&
                        32'(cnt_reg) <  FIRST_READ_BYTE + BYTES_PER_READ * (j + 1))
                        rd_next[j] = {rd_reg[j][READING_W-9:0], st_byte_reg};
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            crc_now_reg   <= CRC_INIT;
            crc_dly_reg   <= CRC_INIT;
            last_byte_reg <= '0;
            addr_ok_reg   <= 1'b0;
            for (int j = 0; j < NUM_READINGS; j++)
                rd_reg[j] <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            crc_now_reg   <= crc_now_next;
            crc_dly_reg   <= crc_dly_next;
            last_byte_reg <= last_byte_next;
            addr_ok_reg   <= addr_ok_next;
            for (int j = 0; j < NUM_READINGS; j++)
                rd_reg[j] <= rd_next[j];
        end
    end

    // Result register valid flag.
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (reply.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Result payload; readings are zeroed for a bad frame.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= status_now;
            for (int j = 0; j < NUM_READINGS; j++)
                out_rd_reg[j] <= (status_now == ST_OK) ? rd_reg[j] : '0;
        end
    end

    // Output channel.
    assign reply.valid        = out_valid_reg;
    assign reply.voltage      = out_rd_reg[0];
    assign reply.current      = out_rd_reg[1];
    assign reply.power        = out_rd_reg[2];
    assign reply.energy       = out_rd_reg[3];
    assign reply.power_factor = out_rd_reg[4];
    assign reply.carbon       = out_rd_reg[5];
    assign reply.status       = out_status_reg;

endmodule

`default_nettype wire
